// ----- rtl/svsp_pkg.sv -----
// Package: shared types, codes and constants of the stepper valve stall positioner.
package svsp_pkg;

    localparam int CYCLES_PER_BLOCK = 15;
    localparam int LIMIT_MARGIN     = 2;
    localparam int TICKS_PER_BLOCK  = 4 * CYCLES_PER_BLOCK;
    localparam int TICK_W           = $clog2(TICKS_PER_BLOCK + 1);

    localparam int POS_W    = 10;
    localparam int SUM_W    = 19;
    localparam int SENSE_W  = 12;
    localparam int CFG_W    = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] POS_MAX        = '1;
    localparam logic [POS_W-1:0] MAX_TRAVEL_RST = POS_W'(255);

    typedef enum logic [1:0] {
        MODE_IDLE        = 2'd0,
        MODE_MOVE        = 2'd1,
        MODE_CAL_RETRACT = 2'd2,
        MODE_CAL_PUSH    = 2'd3
    } run_mode_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CAL   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_STALL     = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RETRACT_CUTOFF = 2'd0,
        REG_PUSH_CUTOFF    = 2'd1,
        REG_MAX_TRAVEL     = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    function automatic logic [3:0] coil_seq(input logic out_dir, input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = out_dir ? 4'h9 : 4'hA;
            2'd1:    pat = out_dir ? 4'h5 : 4'h6;
            2'd2:    pat = out_dir ? 4'h6 : 4'h5;
            default: pat = out_dir ? 4'hA : 4'h9;
        endcase
        return pat;
    endfunction

    function automatic logic [POS_W-1:0] limit_from(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] lim;
        if (pos >= POS_W'(LIMIT_MARGIN)) lim = pos - POS_W'(LIMIT_MARGIN);
        else lim = '0;
        return lim;
    endfunction

endpackage

// ----- rtl/stepper_valve_stall_positioner.sv -----
// Top level: four-phase stepper valve positioner with current-sense stall detection.
//
// Usage: each input transfer carries a command (tick, move to target, calibrate)
// with a target position and two current sense samples. Every accepted item
// yields exactly one result transfer: coil pattern, driver enable, position,
// learned limit, busy flag and status.
// A move or calibrate command starts a run; the run then advances one coil
// phase per tick command, and every 60 ticks the summed sense difference is
// judged against the cutoff of the current direction.
// The result is registered: it appears in the output register in the cycle
// after the input transfer. Throughput: one item per cycle while the receiver
// does not stall, set by the single add-and-compare path from the state
// registers to the result register. When the receiver stalls, the result
// register holds and in_stall rises until the result is taken; a new item is
// accepted in the same cycle the held result leaves.
// Reset clears position, limit and run state, sets both cutoffs to zero and
// the calibration travel to 255 blocks, and empties the result register.
// Configuration writes take effect at the next clock edge.
module stepper_valve_stall_positioner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [svsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svsp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [svsp_pkg::POS_W-1:0]     target_position,
    input  logic [svsp_pkg::SENSE_W-1:0]   sense_a,
    input  logic [svsp_pkg::SENSE_W-1:0]   sense_b,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [3:0]                     coil_pattern,
    output logic                           driver_enable,
    output logic [svsp_pkg::POS_W-1:0]     current_position,
    output logic [svsp_pkg::POS_W-1:0]     limit_position,
    output logic                           busy_res,
    output logic [1:0]                     status
);
    import svsp_pkg::*;

    logic signed [SUM_W-1:0] retract_cut_reg;
    logic signed [SUM_W-1:0] push_cut_reg;
    logic [POS_W-1:0]        max_travel_reg;

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [POS_W-1:0]        limit_reg, limit_next;
    logic [1:0]              phase_reg, phase_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]        blocks_reg, blocks_next;
    logic                    out_dir_reg, out_dir_next;
    run_mode_t               mode_reg, mode_next;

    logic                    out_valid_reg, out_valid_next;
    logic [3:0]              coil_reg, coil_next;
    logic                    drv_reg, drv_next;
    status_t                 status_reg, status_next;

    logic                    accept;
    logic signed [SENSE_W+1:0] diff;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [SUM_W-1:0] cut;
    logic [TICK_W-1:0]       tick_inc;
    logic [POS_W-1:0]        pos_step;
    logic [POS_W-1:0]        blocks_dec;
    logic                    seg_end;
    logic                    driven;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign diff     = $signed({2'b00, sense_b}) - $signed({2'b00, sense_a});
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + (SUM_W+1)'(diff);
    assign tick_inc = tick_reg + TICK_W'(1);
    assign cut      = out_dir_reg ? push_cut_reg : retract_cut_reg;

    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        sum_next     = sum_reg;
        blocks_next  = blocks_reg;
        out_dir_next = out_dir_reg;
        mode_next    = mode_reg;
        coil_next    = 4'h0;
        status_next  = ST_OK;
        driven       = 1'b0;
        seg_end      = 1'b0;
        pos_step     = pos_reg;
        blocks_dec   = blocks_reg;

        case (cmd_t'(cmd))
            CMD_TICK:
            begin
                if (mode_reg != MODE_IDLE) begin
                    driven     = 1'b1;
                    coil_next  = coil_seq(out_dir_reg, phase_reg);
                    phase_next = phase_reg + 2'd1;
                    sum_next   = sum_sat;
                    tick_next  = tick_inc;
                    if (tick_inc >= TICK_W'(TICKS_PER_BLOCK)) begin
                        tick_next  = '0;
                        sum_next   = '0;
                        phase_next = '0;
                        if (sum_sat < cut) begin
                            status_next = ST_STALL;
                            seg_end     = 1'b1;
                        end else begin
                            if (mode_reg != MODE_CAL_RETRACT) begin
                                if (out_dir_reg) begin
                                    if (pos_reg != POS_MAX) pos_step = pos_reg + POS_W'(1);
                                end else if (pos_reg != '0) begin
                                    pos_step = pos_reg - POS_W'(1);
                                end
                            end
                            if (blocks_reg != '0) blocks_dec = blocks_reg - POS_W'(1);
                            pos_next    = pos_step;
                            blocks_next = blocks_dec;
                            if (blocks_dec == '0) seg_end = 1'b1;
                        end
                        if (seg_end) begin
                            case (mode_reg)
                                MODE_CAL_RETRACT:
                                begin
                                    pos_next = '0;
                                    if (max_travel_reg == '0) begin
                                        limit_next = '0;
                                        mode_next  = MODE_IDLE;
                                    end else begin
                                        mode_next    = MODE_CAL_PUSH;
                                        out_dir_next = 1'b1;
                                        blocks_next  = max_travel_reg;
                                    end
                                end
                                MODE_CAL_PUSH:
                                begin
                                    limit_next = limit_from(pos_step);
                                    mode_next  = MODE_IDLE;
                                end
                                default:
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_MOVE:
            begin
                if (mode_reg != MODE_IDLE) begin
                    status_next = ST_REJECTED;
                end else if (target_position > limit_reg) begin
                    status_next = ST_RANGE;
                end else if (target_position != pos_reg) begin
                    mode_next    = MODE_MOVE;
                    out_dir_next = (target_position > pos_reg);
                    blocks_next  = (target_position > pos_reg) ? target_position - pos_reg
                                                               : pos_reg - target_position;
                    tick_next    = '0;
                    sum_next     = '0;
                    phase_next   = '0;
                end
            end
            CMD_CAL:
            begin
                if (mode_reg != MODE_IDLE) begin
                    status_next = ST_REJECTED;
                end else if (max_travel_reg == '0) begin
                    pos_next   = '0;
                    limit_next = '0;
                end else begin
                    mode_next    = MODE_CAL_RETRACT;
                    out_dir_next = 1'b0;
                    blocks_next  = max_travel_reg;
                    tick_next    = '0;
                    sum_next     = '0;
                    phase_next   = '0;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        drv_next = driven | (mode_next != MODE_IDLE);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept) out_valid_next = 1'b1;
        else if (~out_stall) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            retract_cut_reg <= '0;
            push_cut_reg    <= '0;
            max_travel_reg  <= MAX_TRAVEL_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_RETRACT_CUTOFF: retract_cut_reg <= cfg_data[SUM_W-1:0];
                REG_PUSH_CUTOFF:    push_cut_reg    <= cfg_data[SUM_W-1:0];
                REG_MAX_TRAVEL:     max_travel_reg  <= cfg_data[POS_W-1:0];
                default:            max_travel_reg  <= max_travel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            limit_reg     <= '0;
            phase_reg     <= '0;
            tick_reg      <= '0;
            sum_reg       <= '0;
            blocks_reg    <= '0;
            out_dir_reg   <= 1'b0;
            mode_reg      <= MODE_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                pos_reg     <= pos_next;
                limit_reg   <= limit_next;
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                sum_reg     <= sum_next;
                blocks_reg  <= blocks_next;
                out_dir_reg <= out_dir_next;
                mode_reg    <= mode_next;
            end
        end
    end

    // hold result payload until the transfer completes
    always_ff @(posedge clk)
    begin
        if (accept) begin
            coil_reg   <= coil_next;
            drv_reg    <= drv_next;
            status_reg <= status_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign coil_pattern     = coil_reg;
    assign driver_enable    = drv_reg;
    assign current_position = pos_reg;
    assign limit_position   = limit_reg;
    assign busy_res         = (mode_reg != MODE_IDLE);
    assign status           = status_reg;

endmodule
